[src/pcg_pkg.sv]
// shared types, constants and permutation function for the pcg block
`timescale 1ns / 1ps
package pcg_pkg;

  localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;

  // request kinds
  localparam logic [2:0] REQ_RESTART = 3'd0;
  localparam logic [2:0] REQ_DRAW32  = 3'd1;
  localparam logic [2:0] REQ_DRAW64  = 3'd2;
  localparam logic [2:0] REQ_BND32   = 3'd3;
  localparam logic [2:0] REQ_BND64   = 3'd4;

  // register indexes
  localparam logic REG_SEED   = 1'b0;
  localparam logic REG_STREAM = 1'b1;

  // classified command handed from front to back
  typedef struct packed {
    logic [2:0]  kind;
    logic        zero_bound;
    logic [63:0] bound;
  } cmd_t;

  // xsh-rr output permutation of the pre-step state
  function automatic logic [31:0] permute(input logic [63:0] s);
    logic [31:0] mixed;
    logic [4:0]  rot;
    logic [63:0] dbl;
    mixed = 32'(((s >> 18) ^ s) >> 27);
    rot   = s[63:59];
    dbl   = {mixed, mixed} >> rot;
    return dbl[31:0];
  endfunction

endpackage

[src/pcg_front.sv]
// request intake: classifies kinds and zero bounds, two-entry command queue
`timescale 1ns / 1ps
module pcg_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_kind,
  input  logic [63:0]       in_bound,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output pcg_pkg::cmd_t     cmd
);
  import pcg_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       push, pop;

  // classify the request
  always_comb begin
    cmd_in.kind  = in_kind;
    cmd_in.bound = (in_kind == REQ_BND32) ? {32'd0, in_bound[31:0]} : in_bound;
    cmd_in.zero_bound = (in_kind == REQ_BND32) ? (in_bound[31:0] == 32'd0)
                                               : (in_bound == 64'd0);
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cmd_in;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

[src/pcg_divider.sv]
// radix-2 restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
module pcg_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] remainder
);
  import pcg_pkg::*;

  logic [63:0] num, den, rem;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  assign trial     = {rem, num[63]} - {1'b0, den};
  assign remainder = rem;

  // shift-subtract iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= 64'd0;
    end else if (busy) begin
      num <= {num[62:0], 1'b0};
      if (!trial[64]) rem <= trial[63:0];
      else            rem <= {rem[62:0], num[63]};
    end
  end
endmodule

[src/pcg_back.sv]
// generator engine: lcg state, permutation, rejection loop and result register
`timescale 1ns / 1ps
module pcg_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  pcg_pkg::cmd_t     cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_value,
  output logic              out_error
);
  import pcg_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_STEP   = 3'd2;
  localparam logic [2:0] S_TWAIT  = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_MWAIT  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  localparam logic [31:0] MULT_LO = PCG_MULT[31:0];
  localparam logic [31:0] MULT_HI = PCG_MULT[63:32];

  logic [2:0]  state;
  logic [63:0] lcg, inc, seed, stream;
  logic [2:0]  kind;
  logic [63:0] bnd;
  logic [63:0] thresh, raw;
  logic        half;
  logic        div_start, div_done;
  logic [63:0] div_a, div_r;
  logic [1:0]  mphase;
  logic [63:0] acc;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  assign cmd_ready = (state == S_IDLE) && !out_valid;

  // shared 32x32 multiplier: lo*mlo, then hi*mlo and lo*mhi into the upper half
  assign mul_a = (mphase == 2'd1) ? lcg[63:32] : lcg[31:0];
  assign mul_b = (mphase == 2'd2) ? MULT_HI : MULT_LO;
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  pcg_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(bnd), .done(div_done), .remainder(div_r)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed   <= 64'd0;
      stream <= 64'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED:   seed   <= cfg_data;
        REG_STREAM: stream <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lcg       <= 64'd0;
      inc       <= 64'd1;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      mphase    <= 2'd0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            kind      <= cmd.kind;
            bnd       <= cmd.bound;
            out_value <= 64'd0;
            out_error <= 1'b0;
            raw       <= 64'd0;
            half      <= 1'b0;
            if (cmd.kind == REQ_RESTART) begin
              lcg   <= 64'd0;
              inc   <= {stream[62:0], 1'b1};
              state <= S_MUL;
            end else if (cmd.kind == REQ_DRAW32 || cmd.kind == REQ_DRAW64) begin
              state <= S_MUL;
            end else if (cmd.kind == REQ_BND32 || cmd.kind == REQ_BND64) begin
              if (cmd.zero_bound) begin
                out_error <= 1'b1;
                state     <= S_OUT;
              end else begin
                state <= S_TWAIT;
                div_a <= (cmd.kind == REQ_BND32)
                         ? {32'd0, 32'(-cmd.bound[31:0])} : (64'd0 - cmd.bound);
                div_start <= 1'b1;
              end
            end else begin
              state <= S_OUT;
            end
          end
        end
        // product of the state and the multiplier, accumulated over the mphase partial products
        S_MUL: begin
          if (mphase == 2'd0) acc <= mul_p;
          else                acc <= acc + {mul_p[31:0], 32'd0};
          if (mphase == 2'd2) begin
            mphase <= 2'd0;
            state  <= S_STEP;
          end else begin
            mphase <= mphase + 2'd1;
          end
        end
        S_TWAIT: begin
          if (div_done) begin
            thresh <= div_r;
            state  <= S_MUL;
          end
        end
        S_STEP: begin
          if (kind == REQ_RESTART) begin
            // restart: first step adds the seed, second step finishes
            if (!half) begin
              lcg   <= acc + inc + seed;
              half  <= 1'b1;
              state <= S_MUL;
            end else begin
              lcg   <= acc + inc;
              state <= S_OUT;
            end
          end else begin
            lcg <= acc + inc;
            if (kind == REQ_DRAW64 || kind == REQ_BND64) begin
              raw <= {raw[31:0], permute(lcg)};
              if (!half) begin
                half  <= 1'b1;
                state <= S_MUL;
              end else begin
                state <= S_CHECK;
              end
            end else begin
              raw   <= {32'd0, permute(lcg)};
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          half <= 1'b0;
          if (kind == REQ_DRAW32 || kind == REQ_DRAW64) begin
            out_value <= raw;
            state     <= S_OUT;
          end else if (raw < thresh) begin
            state <= S_MUL;
          end else begin
            div_a     <= raw;
            div_start <= 1'b1;
            state     <= S_MWAIT;
          end
        end
        S_MWAIT: begin
          if (div_done) begin
            out_value <= div_r;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[src/permuted_lcg_random_with_bounds.sv]
// top level of the pcg32 generator with bounded draws
`timescale 1ns / 1ps
// Usage:
// Requests enter on s_axis (tuser: req_type[2:0], tdata: bound[63:0]); each
// gives one transfer on m_axis (tdata: value[63:0], tuser: bound_error).
// Kinds: restart, 32-bit draw, 64-bit draw, bounded 32/64-bit draws;
// unknown kinds return zero.
// A front stage classifies requests into a two-entry queue; the back
// engine runs one request at a time and takes the next one the cycle
// after the previous result transfer.
// Each lcg step is a multiply; bounded draws step again for each
// rejected value, and the remainder unit runs twice (threshold, final
// modulo).
// Reset clears the state to 0 and the increment to 1, registers to 0.
// A stalled receiver holds the result register; up to two more requests
// queue in front before s_axis_tready drops.
// Configuration writes (cfg_we, cfg_index, cfg_data) only while idle.
module permuted_lcg_random_with_bounds (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // bound[63:0]
  input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // value[63:0]
  output logic        m_axis_tuser,   // bound_error
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import pcg_pkg::*;

  cmd_t        cmd;
  logic        cmd_valid, cmd_ready;

  pcg_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_kind(s_axis_tuser), .in_bound(s_axis_tdata),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  pcg_back u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_value(m_axis_tdata), .out_error(m_axis_tuser)
  );

  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed under stall");

  // an error result always carries zero value
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
    else $error("error result with nonzero value");

  // no new command taken while a result waits
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !cmd_ready)
    else $error("command taken while result pending");
endmodule

[sim/pcg_checker.sv]
// checker for the pcg generator: predicts each result and compares it with the output stream
`timescale 1ns / 1ps
module pcg_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  import pcg_pkg::*;

  typedef struct packed {
    logic [63:0] value;
    logic        bound_error;
  } rand_result_t;

  logic [63:0] gen_state;
  logic [63:0] gen_inc;
  logic [63:0] seed_reg;
  logic [63:0] stream_reg;
  rand_result_t want_q[$];

  // one generator step, returning the permuted pre-step state
  function automatic logic [31:0] gen_next32(ref logic [63:0] st, input logic [63:0] inc);
    logic [63:0] old;
    logic [31:0] mixed;
    logic [4:0]  rot;
    old = st;
    st = old * PCG_MULT + inc;
    mixed = 32'(((old >> 18) ^ old) >> 27);
    rot = old[63:59];
    return (mixed >> rot) | (mixed << ((32 - rot) & 31));
  endfunction

  // work out the result of one request and advance the model state
  function automatic rand_result_t gen_request(input logic [2:0] kind, input logic [63:0] bnd);
    rand_result_t res;
    logic [31:0] b32, th32, r32, junk;
    logic [63:0] th64, r64;
    res = '0;
    case (kind)
      REQ_RESTART: begin
        gen_state = '0;
        gen_inc = {stream_reg[62:0], 1'b1};
        junk = gen_next32(gen_state, gen_inc);
        gen_state = gen_state + seed_reg;
        junk = gen_next32(gen_state, gen_inc);
      end
      REQ_DRAW32: res.value = {32'd0, gen_next32(gen_state, gen_inc)};
      REQ_DRAW64: begin
        res.value[63:32] = gen_next32(gen_state, gen_inc);
        res.value[31:0] = gen_next32(gen_state, gen_inc);
      end
      REQ_BND32: begin
        b32 = bnd[31:0];
        if (b32 == 0) begin
          res.bound_error = 1'b1;
        end else begin
          th32 = (32'd0 - b32) % b32;
          do r32 = gen_next32(gen_state, gen_inc); while (r32 < th32);
          res.value = {32'd0, r32 % b32};
        end
      end
      REQ_BND64: begin
        if (bnd == 0) begin
          res.bound_error = 1'b1;
        end else begin
          th64 = (64'd0 - bnd) % bnd;
          do begin
            r64[63:32] = gen_next32(gen_state, gen_inc);
            r64[31:0] = gen_next32(gen_state, gen_inc);
          end while (r64 < th64);
          res.value = r64 % bnd;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  assign pending_count = want_q.size();

  // watch config, request and result transfers
  always @(posedge clk) begin
    rand_result_t got, want;
    int errs;
    errs = 0;
    if (rst) begin
      gen_state <= '0;
      gen_inc <= 64'd1;
      seed_reg <= '0;
      stream_reg <= '0;
      fail_count <= 0;
      result_count <= 0;
      want_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SEED) seed_reg = cfg_data;
        else stream_reg = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready)
        want_q.push_back(gen_request(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata;
        got.bound_error = m_axis_tuser;
        result_count <= result_count + 1;
        if (want_q.size() == 0) begin
          $error("result transfer with nothing expected: value %h", got.value);
          errs++;
        end else begin
          want = want_q.pop_front();
          if (got.value !== want.value) begin
            $error("value: expected %h actual %h", want.value, got.value);
            errs++;
          end
          if (got.bound_error !== want.bound_error) begin
            $error("bound_error: expected %b actual %b", want.bound_error, got.bound_error);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

[sim/tb.sv]
// testbench top: drives requests and configuration into the pcg block and gives the verdict
`timescale 1ns / 1ps
module tb;
  import pcg_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 650;
  localparam int HOLD_OFF = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;
  int          fail_count, pending_count, result_count;
  int          cycle_count = 0;
  bit          hold_done = 1'b0;

  always #5 clk = ~clk;

  permuted_lcg_random_with_bounds u_top (.*);

  pcg_checker u_chk (.*);

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: one long hold-off early on, then random stalls
  initial begin
    int gap;
    repeat (11) @(negedge clk);
    repeat (HOLD_OFF) @(negedge clk);
    hold_done = 1'b1;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // offer one request and wait for its transfer
  task automatic send_req(input logic [2:0] kind, input logic [63:0] bnd, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= bnd;
    s_axis_tuser <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // write a register once the block has drained
  task automatic write_reg(input logic idx, input logic [63:0] data);
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random bound: small, 32-bit, full-width, near the top, just above 2^63, or a wide upper word
  function automatic logic [63:0] rand_bound();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 20));
      1: return 64'($urandom);
      2: return rand64();
      3: return 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 8));
      4: return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
      default: return {$urandom, 32'd0} | 64'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    logic [2:0] kind;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: draws from reset state, all kinds, extreme and zero bounds
    send_req(REQ_DRAW32, 64'd0, 1'b0);
    send_req(REQ_DRAW64, 64'd0, 1'b0);
    send_req(REQ_RESTART, rand64(), 1'b0);
    send_req(REQ_DRAW32, 64'd0, 1'b0);
    send_req(REQ_BND32, 64'd0, 1'b0);
    send_req(REQ_BND32, 64'hffff_ffff_0000_0000, 1'b0);
    send_req(REQ_BND32, 64'd1, 1'b0);
    send_req(REQ_BND32, 64'hffff_ffff, 1'b0);
    send_req(REQ_BND32, 64'h8000_0001, 1'b0);
    send_req(REQ_BND64, 64'd0, 1'b0);
    send_req(REQ_BND64, 64'd1, 1'b0);
    send_req(REQ_BND64, 64'hffff_ffff_ffff_ffff, 1'b0);
    send_req(REQ_BND64, 64'h8000_0000_0000_0001, 1'b0);
    send_req(REQ_BND64, 64'd7, 1'b0);
    send_req(3'd5, 64'd0, 1'b0);
    send_req(3'd6, rand64(), 1'b0);
    send_req(3'd7, 64'hffff_ffff_ffff_ffff, 1'b0);
    send_req(REQ_DRAW64, 64'd0, 1'b0);

    // register extremes
    write_reg(REG_SEED, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_STREAM, 64'hffff_ffff_ffff_ffff);
    send_req(REQ_RESTART, 64'd0, 1'b0);
    send_req(REQ_DRAW64, 64'd0, 1'b0);
    send_req(REQ_BND64, 64'd3, 1'b0);

    // random phases, each with fresh register values
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 130 == 0) begin
        write_reg(REG_SEED, (i == 260) ? 64'd0 : rand64());
        write_reg(REG_STREAM, (i == 260) ? 64'd0 : rand64());
        send_req(REQ_RESTART, rand64(), 1'b0);
      end
      case ($urandom_range(0, 19))
        0:           kind = REQ_RESTART;
        1:           kind = 3'($urandom_range(5, 7));
        2, 3, 4, 5:  kind = REQ_DRAW32;
        6, 7, 8, 9:  kind = REQ_DRAW64;
        10, 11, 12:  kind = REQ_BND32;
        default:     kind = REQ_BND64;
      endcase
      // no gaps while the receiver holds off, so the input stalls
      send_req(kind, rand_bound(), !hold_done || ($urandom_range(0, 3) == 0));
    end
    s_axis_tvalid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("covered restarts, plain and bounded draws with zero and extreme bounds,");
    $display("unknown kinds and %0d results checked under random stalls", result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
